@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define HTC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define HTC_ASSERT_NEVER(name, clk, rst_n, cond) \
  `HTC_ASSERT(name, clk, rst_n, !(cond))

`endif

@@ rtl/htc_pkg.sv @@
// Widths and fixed-point constants of the humidity/temperature converter.
package htc_pkg;

  localparam int unsigned RawW    = 12;
  localparam int unsigned OffsetW = 13;
  localparam int unsigned TempW   = 15;
  localparam int unsigned HumW    = 14;
  localparam int unsigned InDataW  = 24;  // 2 x 12 bits, already byte aligned
  localparam int unsigned OutDataW = 32;  // 15 + 14 bits, padded to bytes

  localparam logic [OffsetW-1:0] TempOffsetRst = 13'd4010;

  // Linearization constants
  localparam logic signed [31:0] HumC1 = -32'sd400;
  localparam logic signed [31:0] HumC2 = 32'sd1087163596;
  localparam logic signed [31:0] HumC3 = -32'sd300647;
  // Temperature compensation constants
  localparam logic [28:0] HumT1 = 29'd10737418;
  localparam logic [28:0] HumT2 = 29'd85899;

  localparam logic signed [15:0] TempRef = 16'sd2500;
  localparam logic [31:0]        RoundHalf = 32'd65536;
  localparam logic signed [15:0] HumMax = 16'sd9999;
  localparam logic signed [15:0] HumMin = 16'sd1;

endpackage

@@ rtl/humidity_temp_compensation_core.sv @@
// Top level: pipelined humidity and temperature conversion with compensation.
// Each accepted request passes through stages 1 to 4 into the output register.
// Throughput: one request per cycle while the output is not stalled; each of the four
// stages has its own valid bit and loads whenever it is empty or its successor moves on.
// Reset: clears all valid bits and loads temp_offset with 4010; no clearing pass.
`include "assert_macros.svh"

module humidity_temp_compensation_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [htc_pkg::OffsetW-1:0]    cfg_wdata_i,     // temp_offset
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [htc_pkg::InDataW-1:0]    s_axis_tdata_i,  // [11:0] temp_raw, [23:12] hum_raw
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [htc_pkg::OutDataW-1:0]   m_axis_tdata_o   // [14:0] temperature,
                                                          // [28:15] humidity, [31:29] zero
);
  import htc_pkg::*;

  logic [OffsetW-1:0] temp_offset_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1: scaled temperature, two products of the raw humidity
  logic [RawW-1:0]         traw;
  logic [RawW-1:0]         h1_d, h1_q;
  logic signed [TempW-1:0] temp1_d, temp1_q;
  logic signed [31:0]      c3p_d, c3p_q;
  logic [28:0]             tsum_d, tsum_q;

  // stage 2: linear coefficient, temperature delta, compensation slope
  logic signed [31:0]      lsum;
  logic [19:0]             lina_d, lina_q;
  logic signed [15:0]      tdel_d, tdel_q;
  logic [15:0]             slope_d, slope_q;
  logic [RawW-1:0]         h2_q;
  logic signed [TempW-1:0] temp2_q;

  // stage 3: the two remaining products
  logic [31:0]             linp_d, linp_q;
  logic signed [31:0]      compp_d, compp_q;
  logic signed [TempW-1:0] temp3_q;

  // stage 4: sum, clamp
  logic [31:0]             lrnd;
  logic signed [15:0]      lin;
  logic signed [15:0]      comp;
  logic signed [15:0]      hsum;
  logic [HumW-1:0]         hum_d, hum_q;
  logic signed [TempW-1:0] temp4_q;

  // a stage loads when empty or when its contents move on
  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_offset_q <= TempOffsetRst;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        temp_offset_q <= cfg_wdata_i;
      end
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_comb begin
    traw    = s_axis_tdata_i[RawW-1:0];
    h1_d    = s_axis_tdata_i[2*RawW-1:RawW];
    temp1_d = TempW'({1'b0, traw, 2'b00} - {2'b00, temp_offset_q});
    c3p_d   = HumC3 * $signed({20'd0, h1_d});
    tsum_d  = HumT1 + HumT2 * {17'd0, h1_d};
  end

  always_comb begin
    // the sum stays positive over the whole input range
    lsum    = (c3p_q >>> 2) + HumC2;
    lina_d  = lsum[30:11];
    tdel_d  = $signed({temp1_q[TempW-1], temp1_q}) - TempRef;
    slope_d = tsum_q[28:13];
  end

  always_comb begin
    linp_d  = {12'd0, lina_q} * {20'd0, h2_q};
    compp_d = $signed({{16{tdel_q[15]}}, tdel_q}) * $signed({16'd0, slope_q});
  end

  always_comb begin
    lrnd = linp_q + RoundHalf;
    lin  = $signed({2'b00, lrnd[30:17]}) + HumC1[15:0];
    comp = $signed({compp_q[31], compp_q[31:17]});
    hsum = lin + comp;
    if (hsum > HumMax) begin
      hum_d = HumW'(HumMax);
    end else if (hsum < HumMin) begin
      hum_d = HumW'(HumMin);
    end else begin
      hum_d = hsum[HumW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      h1_q    <= h1_d;
      temp1_q <= temp1_d;
      c3p_q   <= c3p_d;
      tsum_q  <= tsum_d;
    end
    if (en2) begin
      lina_q  <= lina_d;
      tdel_q  <= tdel_d;
      slope_q <= slope_d;
      h2_q    <= h1_q;
      temp2_q <= temp1_q;
    end
    if (en3) begin
      linp_q  <= linp_d;
      compp_q <= compp_d;
      temp3_q <= temp2_q;
    end
    if (en4) begin
      hum_q   <= hum_d;
      temp4_q <= temp3_q;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {3'b000, hum_q, temp4_q};

  `HTC_ASSERT(a_accept_fills_s1, clk_i, rst_ni,
              (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
  `HTC_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
              !s_axis_tready_o |-> (v1_q && v2_q && v3_q && v4_q && !m_axis_tready_i))
  `HTC_ASSERT_NEVER(a_hum_range, clk_i, rst_ni,
                    m_axis_tvalid_o && (hum_q == '0 || hum_q > 14'd9999))
  `HTC_ASSERT_NEVER(a_temp_range, clk_i, rst_ni,
                    m_axis_tvalid_o && (temp4_q < -15'sd8191))

endmodule
